// ----- rtl/rpp_pkg.sv -----
// Package: shared constants, codes and types of the reader progress percentile block.
`timescale 1ns / 1ps

package rpp_pkg;

    localparam int USER_COUNT = 131072;
    localparam int MAX_PAGE   = 1023;
    localparam int FRAC_BITS  = 16;

    localparam int UID_W    = 17;
    localparam int PAGE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = FRAC_BITS + 1;

    localparam int UADDR_W   = $clog2(USER_COUNT);
    localparam int HIST_DEPTH = MAX_PAGE + 1;
    localparam int HADDR_W   = $clog2(HIST_DEPTH);
    localparam int CNT_W     = $clog2(USER_COUNT + 1);
    localparam int ALU_W     = CNT_W + 1;
    localparam int DVD_W     = CNT_W + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(64'(1) << FRAC_BITS);

    typedef enum logic [STATUS_W-1:0] {
        STAT_READ     = 2'd0,
        STAT_QUERY    = 2'd1,
        STAT_BAD_USER = 2'd2,
        STAT_BAD_PAGE = 2'd3
    } status_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_USR_GOT,
        ST_DEC_WR,
        ST_INC_RD,
        ST_INC_WR,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             borrow;
    } alu_res_t;

endpackage

// ----- rtl/rpp_req_if.sv -----
// Interface: request channel (operation, user id, page).
`timescale 1ns / 1ps

interface rpp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [rpp_pkg::UID_W-1:0]   user_id;
    logic [rpp_pkg::PAGE_W-1:0]  page;

    modport source (output valid, operation, user_id, page, input ready);
    modport sink   (input valid, operation, user_id, page, output ready);
endinterface

// ----- rtl/rpp_rsp_if.sv -----
// Interface: result channel (status, fraction).
`timescale 1ns / 1ps

interface rpp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rpp_pkg::STATUS_W-1:0]  status;
    logic [rpp_pkg::FRAC_W-1:0]    fraction;

    modport source (output valid, status, fraction, input ready);
    modport sink   (input valid, status, fraction, output ready);
endinterface

// ----- rtl/reader_progress_percentile_top.sv -----
// A rejected request, a read (first or later) and a query on an unseen or sole reader finish
// without division; other queries sum the histogram entries below the user's page p, one
// entry per cycle, then run 34 division steps. One request at a time: the next is taken the
// cycle after the result enters the output register, which waits while the previous result
// is still held there.
// After reset a clearing pass zeroes both memories; no request is accepted in it.
`timescale 1ns / 1ps

module reader_progress_percentile_top (
    input  logic      clk,
    input  logic      rst_n,
    rpp_req_if.sink   req,
    rpp_rsp_if.source rsp
);

    rpp_pkg::alu_req_t               alu_req;
    rpp_pkg::alu_res_t               alu_res;
    logic                            u_we;
    logic [rpp_pkg::UADDR_W-1:0]     u_waddr;
    logic [rpp_pkg::PAGE_W-1:0]      u_wdata;
    logic                            u_re;
    logic [rpp_pkg::UADDR_W-1:0]     u_raddr;
    logic [rpp_pkg::PAGE_W-1:0]      u_rdata;
    logic                            h_we;
    logic [rpp_pkg::HADDR_W-1:0]     h_waddr;
    logic [rpp_pkg::CNT_W-1:0]       h_wdata;
    logic                            h_re;
    logic [rpp_pkg::HADDR_W-1:0]     h_raddr;
    logic [rpp_pkg::CNT_W-1:0]       h_rdata;

    rpp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .alu_req (alu_req),
        .alu_res (alu_res),
        .u_we    (u_we),
        .u_waddr (u_waddr),
        .u_wdata (u_wdata),
        .u_re    (u_re),
        .u_raddr (u_raddr),
        .u_rdata (u_rdata),
        .h_we    (h_we),
        .h_waddr (h_waddr),
        .h_wdata (h_wdata),
        .h_re    (h_re),
        .h_raddr (h_raddr),
        .h_rdata (h_rdata)
    );

    rpp_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // last page read per user
    rpp_ram #(
        .WIDTH (rpp_pkg::PAGE_W),
        .DEPTH (rpp_pkg::USER_COUNT)
    ) u_user_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (u_re),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // readers per page
    rpp_ram #(
        .WIDTH (rpp_pkg::CNT_W),
        .DEPTH (rpp_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

endmodule

// ----- rtl/rpp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rpp_alu.sv -----
// Shared add/subtract unit used for counters, histogram sums and division steps.
`timescale 1ns / 1ps

module rpp_alu (
    input  rpp_pkg::alu_req_t req,
    output rpp_pkg::alu_res_t res
);

    logic [rpp_pkg::ALU_W-1:0] b_op;
    logic [rpp_pkg::ALU_W:0]   wide;

    always_comb
    begin
        b_op       = req.sub ? ~req.b : req.b;
        wide       = (rpp_pkg::ALU_W + 1)'(req.a) + (rpp_pkg::ALU_W + 1)'(b_op)
                   + (rpp_pkg::ALU_W + 1)'(req.sub);
        res.sum    = wide[rpp_pkg::ALU_W-1:0];
        res.borrow = req.sub & ~wide[rpp_pkg::ALU_W];
    end

endmodule

// ----- rtl/rpp_ctrl.sv -----
// Sequencer and datapath registers: clear pass, read update, query sum and division.
`timescale 1ns / 1ps

module rpp_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    rpp_req_if.sink                       req,
    rpp_rsp_if.source                     rsp,
    output rpp_pkg::alu_req_t             alu_req,
    input  rpp_pkg::alu_res_t             alu_res,
    output logic                          u_we,
    output logic [rpp_pkg::UADDR_W-1:0]   u_waddr,
    output logic [rpp_pkg::PAGE_W-1:0]    u_wdata,
    output logic                          u_re,
    output logic [rpp_pkg::UADDR_W-1:0]   u_raddr,
    input  logic [rpp_pkg::PAGE_W-1:0]    u_rdata,
    output logic                          h_we,
    output logic [rpp_pkg::HADDR_W-1:0]   h_waddr,
    output logic [rpp_pkg::CNT_W-1:0]     h_wdata,
    output logic                          h_re,
    output logic [rpp_pkg::HADDR_W-1:0]   h_raddr,
    input  logic [rpp_pkg::CNT_W-1:0]     h_rdata
);

    rpp_pkg::state_t                state_reg, state_next;
    logic [rpp_pkg::UADDR_W-1:0]    clr_reg, clr_next;
    logic                           op_reg, op_next;
    logic [rpp_pkg::UID_W-1:0]      uid_reg, uid_next;
    logic [rpp_pkg::PAGE_W-1:0]     page_reg, page_next;
    logic [rpp_pkg::PAGE_W-1:0]     p_reg, p_next;
    logic [rpp_pkg::CNT_W-1:0]      total_reg, total_next;
    logic [rpp_pkg::CNT_W-1:0]      dsr_reg, dsr_next;
    logic [rpp_pkg::CNT_W-1:0]      acc_reg, acc_next;
    logic [rpp_pkg::HADDR_W-1:0]    idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic [rpp_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [rpp_pkg::DVD_W-1:0]      dvd_reg, dvd_next;
    logic [rpp_pkg::DCNT_W-1:0]     cnt_reg, cnt_next;
    rpp_pkg::status_t               stat_reg, stat_next;
    logic [rpp_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic                           out_valid_reg, out_valid_next;
    rpp_pkg::status_t               out_stat_reg, out_stat_next;
    logic [rpp_pkg::FRAC_W-1:0]     out_frac_reg, out_frac_next;

    logic                           uid_bad;
    logic                           page_bad;
    logic                           prev_zero;
    logic                           total_le1;
    logic                           issue;
    logic                           out_free;
    logic                           last_step;
    logic [rpp_pkg::ALU_W-1:0]      trial;

    always_comb
    begin
        uid_bad   = 32'(uid_reg) >= 32'(rpp_pkg::USER_COUNT);
        page_bad  = (page_reg == '0) || (32'(page_reg) > 32'(rpp_pkg::MAX_PAGE));
        prev_zero = (u_rdata == '0);
        total_le1 = (total_reg <= rpp_pkg::CNT_W'(1));
        issue     = 32'(idx_reg) < 32'(p_reg);
        out_free  = !out_valid_reg || rsp.ready;
        last_step = (cnt_reg == rpp_pkg::DCNT_W'(rpp_pkg::DIV_STEPS - 1));
        trial     = {rem_reg, dvd_reg[rpp_pkg::DVD_W-1]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpp_pkg::ST_CLEAR:
            begin
                if (clr_reg == rpp_pkg::UADDR_W'(rpp_pkg::USER_COUNT - 1))
                begin
                    state_next = rpp_pkg::ST_IDLE;
                end
            end
            rpp_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = rpp_pkg::ST_CHECK;
                end
            end
            rpp_pkg::ST_CHECK:
            begin
                if (uid_bad || (op_reg == rpp_pkg::OP_READ && page_bad))
                begin
                    state_next = rpp_pkg::ST_FIN;
                end
                else
                begin
                    state_next = rpp_pkg::ST_USR_GOT;
                end
            end
            rpp_pkg::ST_USR_GOT:
            begin
                if (op_reg == rpp_pkg::OP_READ)
                begin
                    state_next = prev_zero ? rpp_pkg::ST_INC_RD : rpp_pkg::ST_DEC_WR;
                end
                else
                begin
                    state_next = (prev_zero || total_le1) ? rpp_pkg::ST_FIN : rpp_pkg::ST_SUM;
                end
            end
            rpp_pkg::ST_DEC_WR: state_next = rpp_pkg::ST_INC_RD;
            rpp_pkg::ST_INC_RD: state_next = rpp_pkg::ST_INC_WR;
            rpp_pkg::ST_INC_WR: state_next = rpp_pkg::ST_FIN;
            rpp_pkg::ST_SUM:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = rpp_pkg::ST_DIV;
                end
            end
            rpp_pkg::ST_DIV:
            begin
                if (last_step)
                begin
                    state_next = rpp_pkg::ST_FIN;
                end
            end
            rpp_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = rpp_pkg::ST_IDLE;
                end
            end
            default: state_next = rpp_pkg::ST_CLEAR;
        endcase
    end

    // memory, ALU and handshake controls
    always_comb
    begin
        req.ready   = 1'b0;
        alu_req     = '0;
        u_we        = 1'b0;
        u_waddr     = rpp_pkg::UADDR_W'(uid_reg);
        u_wdata     = page_reg;
        u_re        = 1'b0;
        u_raddr     = rpp_pkg::UADDR_W'(uid_reg);
        h_we        = 1'b0;
        h_waddr     = rpp_pkg::HADDR_W'(page_reg);
        h_wdata     = alu_res.sum[rpp_pkg::CNT_W-1:0];
        h_re        = 1'b0;
        h_raddr     = rpp_pkg::HADDR_W'(page_reg);
        case (state_reg)
            rpp_pkg::ST_CLEAR:
            begin
                u_we    = 1'b1;
                u_waddr = clr_reg;
                u_wdata = '0;
                h_we    = 1'b1;
                h_waddr = clr_reg[rpp_pkg::HADDR_W-1:0];
                h_wdata = '0;
            end
            rpp_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            rpp_pkg::ST_CHECK:
            begin
                u_re = !(uid_bad || (op_reg == rpp_pkg::OP_READ && page_bad));
            end
            rpp_pkg::ST_USR_GOT:
            begin
                alu_req.a = rpp_pkg::ALU_W'(total_reg);
                alu_req.b = rpp_pkg::ALU_W'(1);
                if (op_reg == rpp_pkg::OP_READ)
                begin
                    alu_req.sub = 1'b0;
                    h_re        = !prev_zero;
                    h_raddr     = rpp_pkg::HADDR_W'(u_rdata);
                end
                else
                begin
                    alu_req.sub = 1'b1;
                end
            end
            rpp_pkg::ST_DEC_WR:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = rpp_pkg::ALU_W'(h_rdata);
                alu_req.b   = rpp_pkg::ALU_W'(1);
                h_we        = 1'b1;
                h_waddr     = rpp_pkg::HADDR_W'(p_reg);
            end
            rpp_pkg::ST_INC_RD:
            begin
                h_re = 1'b1;
            end
            rpp_pkg::ST_INC_WR:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = rpp_pkg::ALU_W'(h_rdata);
                alu_req.b   = rpp_pkg::ALU_W'(1);
                h_we        = 1'b1;
                u_we        = 1'b1;
            end
            rpp_pkg::ST_SUM:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = rpp_pkg::ALU_W'(acc_reg);
                alu_req.b   = pend_reg ? rpp_pkg::ALU_W'(h_rdata) : '0;
                h_re        = issue;
                h_raddr     = idx_reg;
            end
            rpp_pkg::ST_DIV:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = trial;
                alu_req.b   = rpp_pkg::ALU_W'(dsr_reg);
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_next       = clr_reg;
        op_next        = op_reg;
        uid_next       = uid_reg;
        page_next      = page_reg;
        p_next         = p_reg;
        total_next     = total_reg;
        dsr_next       = dsr_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        stat_next      = stat_reg;
        frac_next      = frac_reg;
        out_stat_next  = out_stat_reg;
        out_frac_next  = out_frac_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            rpp_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            rpp_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.operation;
                    uid_next  = req.user_id;
                    page_next = req.page;
                end
            end
            rpp_pkg::ST_CHECK:
            begin
                frac_next = '0;
                stat_next = uid_bad ? rpp_pkg::STAT_BAD_USER : rpp_pkg::STAT_BAD_PAGE;
            end
            rpp_pkg::ST_USR_GOT:
            begin
                p_next = u_rdata;
                if (op_reg == rpp_pkg::OP_READ)
                begin
                    if (prev_zero)
                    begin
                        total_next = alu_res.sum[rpp_pkg::CNT_W-1:0];
                    end
                end
                else
                begin
                    dsr_next  = alu_res.sum[rpp_pkg::CNT_W-1:0];
                    stat_next = rpp_pkg::STAT_QUERY;
                    frac_next = (!prev_zero && total_le1) ? rpp_pkg::FRAC_ONE : '0;
                    idx_next  = rpp_pkg::HADDR_W'(1);
                    pend_next = 1'b0;
                    acc_next  = '0;
                end
            end
            rpp_pkg::ST_INC_WR:
            begin
                stat_next = rpp_pkg::STAT_READ;
                frac_next = '0;
            end
            rpp_pkg::ST_SUM:
            begin
                acc_next  = alu_res.sum[rpp_pkg::CNT_W-1:0];
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    dvd_next  = {acc_reg, {rpp_pkg::FRAC_BITS{1'b0}}};
                    rem_next  = '0;
                    cnt_next  = '0;
                    frac_next = '0;
                end
            end
            rpp_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (alu_res.borrow)
                begin
                    rem_next = trial[rpp_pkg::CNT_W-1:0];
                end
                else
                begin
                    rem_next = alu_res.sum[rpp_pkg::CNT_W-1:0];
                end
                frac_next = {frac_reg[rpp_pkg::FRAC_W-2:0], !alu_res.borrow};
                dvd_next  = {dvd_reg[rpp_pkg::DVD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
            end
            rpp_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_frac_next  = frac_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpp_pkg::ST_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        uid_reg      <= uid_next;
        page_reg     <= page_next;
        p_reg        <= p_next;
        dsr_reg      <= dsr_next;
        acc_reg      <= acc_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        cnt_reg      <= cnt_next;
        stat_reg     <= stat_next;
        frac_reg     <= frac_next;
        out_stat_reg <= out_stat_next;
        out_frac_reg <= out_frac_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_stat_reg;
    assign rsp.fraction = out_frac_reg;

    a_frac_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != rpp_pkg::STAT_QUERY) |-> rsp.fraction == '0)
        else $error("fraction nonzero on non-query result");

    a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.fraction <= rpp_pkg::FRAC_ONE)
        else $error("fraction above 1.0");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("reader total decreased");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rpp_pkg::ST_SUM |-> acc_reg < total_reg)
        else $error("lower-reader sum reached reader total");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rpp_pkg::ST_DIV |-> rem_reg < dsr_reg)
        else $error("division remainder not below divisor");

endmodule

// ----- verif/tb_reader_progress_percentile_top.sv -----
// Testbench: directed and random reads/queries on reader_progress_percentile_top, checked per request.
`timescale 1ns / 1ps

module tb_reader_progress_percentile_top;
    import rpp_pkg::*;

    localparam int POOL_SIZE = 48;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        op_t               op;
        logic [UID_W-1:0]  uid;
        logic [PAGE_W-1:0] page;
    } page_req_t;

    typedef struct {
        status_t           status;
        logic [FRAC_W-1:0] fraction;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rpp_req_if req_ch ();
    rpp_rsp_if rsp_ch ();

    reader_progress_percentile_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow of the block's reader state
    logic [PAGE_W-1:0] page_of_user [USER_COUNT];
    int unsigned       readers_on_page [HIST_DEPTH];
    int unsigned       reader_total;

    page_req_t         pending_reqs [$];
    reply_t            replies_due [$];
    page_req_t         next_req;
    reply_t            due;
    logic [UID_W-1:0]  user_pool [POOL_SIZE];
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatches = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [FRAC_W-1:0] percentile_of(logic [UID_W-1:0] uid);
        int unsigned       p;
        longint unsigned   lower;
        p = page_of_user[uid];
        lower = 0;
        if (p == 0)
            return '0;
        if (reader_total <= 1)
            return FRAC_ONE;
        for (int i = 1; i < p; i++)
            lower += readers_on_page[i];
        return FRAC_W'((lower << FRAC_BITS) / longint'(reader_total - 1));
    endfunction

    task automatic score_request(op_t op, logic [UID_W-1:0] uid, logic [PAGE_W-1:0] pg);
        reply_t            r;
        logic [PAGE_W-1:0] prev;
        r.fraction = '0;
        if (uid >= USER_COUNT)
            r.status = STAT_BAD_USER;
        else if (op == OP_READ)
        begin
            if (pg == 0 || pg > MAX_PAGE)
                r.status = STAT_BAD_PAGE;
            else
            begin
                prev = page_of_user[uid];
                if (prev == 0)
                    reader_total++;
                else
                    readers_on_page[prev]--;
                readers_on_page[pg]++;
                page_of_user[uid] = pg;
                r.status = STAT_READ;
            end
        end
        else
        begin
            r.fraction = percentile_of(uid);
            r.status = STAT_QUERY;
        end
        replies_due.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_READ;
            req_ch.user_id   <= '0;
            req_ch.page      <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                score_request(op_t'(req_ch.operation), req_ch.user_id, req_ch.page);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= next_req.op;
                    req_ch.user_id   <= next_req.uid;
                    req_ch.page      <= next_req.page;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected reply: status=%0d fraction=%0d",
                                 rsp_ch.status, rsp_ch.fraction);
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp_ch.status !== due.status || rsp_ch.fraction !== due.fraction)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: status exp=%0d got=%0d, fraction exp=%0d got=%0d",
                                     due.status, rsp_ch.status, due.fraction, rsp_ch.fraction);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_req(op_t op, logic [UID_W-1:0] uid, logic [PAGE_W-1:0] pg);
        page_req_t r;
        r.op = op;
        r.uid = uid;
        r.page = pg;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || replies_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        int               pick;
        logic [UID_W-1:0] uid;
        logic [PAGE_W-1:0] pg;
        drain();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 85)
                uid = user_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                uid = UID_W'($urandom());
            if ($urandom_range(0, 99) < 55)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    pg = '0;
                else if (pick < 50)
                    pg = PAGE_W'($urandom_range(1, 24));
                else if (pick < 58)
                    pg = PAGE_W'(MAX_PAGE);
                else
                    pg = PAGE_W'($urandom_range(1, MAX_PAGE));
                push_req(OP_READ, uid, pg);
            end
            else
                push_req(OP_QUERY, uid, PAGE_W'($urandom()));
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_READ;
        req_ch.user_id = '0;
        req_ch.page = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < USER_COUNT; i++)
            page_of_user[i] = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            readers_on_page[i] = 0;
        reader_total = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            user_pool[i] = UID_W'($urandom());
        user_pool[0] = '0;
        user_pool[1] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unseen user, bad page, sole reader, ties, moves, extremes
        push_req(OP_QUERY, '0, '1);
        push_req(OP_READ, '0, '0);
        push_req(OP_READ, '0, PAGE_W'(MAX_PAGE));
        push_req(OP_QUERY, '0, '0);
        push_req(OP_READ, '1, 10'd1);
        push_req(OP_QUERY, '1, '1);
        push_req(OP_QUERY, '0, '0);
        push_req(OP_READ, '0, PAGE_W'(MAX_PAGE));
        push_req(OP_QUERY, '0, PAGE_W'(MAX_PAGE));
        push_req(OP_READ, 17'd5, 10'd512);
        push_req(OP_QUERY, 17'd5, 10'd0);
        push_req(OP_READ, 17'd6, 10'd2);
        push_req(OP_READ, 17'd7, 10'd2);
        push_req(OP_QUERY, 17'd7, PAGE_W'(MAX_PAGE));
        push_req(OP_QUERY, 17'd6, 10'd2);
        push_req(OP_READ, '0, 10'd1);
        push_req(OP_QUERY, 17'd5, 10'd0);
        push_req(OP_QUERY, '0, 10'd0);
        push_req(OP_QUERY, 17'd3, 10'd3);
        push_req(OP_READ, 17'd1, '0);
        push_req(OP_QUERY, 17'd1, 10'd1);
        push_req(OP_READ, 17'h0AAAA, 10'h155);
        push_req(OP_READ, 17'h15555, 10'h2AA);
        push_req(OP_QUERY, 17'h15555, '0);

        run_phase(135, 0, 0);
        run_phase(135, 88, 0);
        run_phase(135, 0, 88);
        run_phase(135, 11, 11);
        drain();
        repeat (1100) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
